@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL of the sensor bus master.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/hsbm_pkg.sv @@
// Package with the command codes, sensor opcodes and field widths of the sensor bus master.
package hsbm_pkg;

   localparam int CMD_W      = 3;
   localparam int BYTE_W     = 8;
   localparam int VALUE_W    = 16;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   // Command selector carried by each request transfer.
   localparam logic [CMD_W-1:0] CMD_NONE         = 3'd0;
   localparam logic [CMD_W-1:0] CMD_TEMPERATURE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_HUMIDITY     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ_STATUS  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_WRITE_STATUS = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SOFT_RESET   = 3'd5;

   // Opcodes sent to the sensor.
   localparam logic [BYTE_W-1:0] OP_MEAS_TEMP     = 8'h03;
   localparam logic [BYTE_W-1:0] OP_MEAS_HUMIDITY = 8'h05;
   localparam logic [BYTE_W-1:0] OP_READ_STATUS   = 8'h07;
   localparam logic [BYTE_W-1:0] OP_WRITE_STATUS  = 8'h06;
   localparam logic [BYTE_W-1:0] OP_SOFT_RESET    = 8'h1e;
   localparam logic [BYTE_W-1:0] OP_NONE          = 8'h00;

   function automatic logic [BYTE_W-1:0] opcode_of(input logic [CMD_W-1:0] cmd);
      logic [BYTE_W-1:0] op;
      unique case (cmd)
         CMD_TEMPERATURE:  op = OP_MEAS_TEMP;
         CMD_HUMIDITY:     op = OP_MEAS_HUMIDITY;
         CMD_READ_STATUS:  op = OP_READ_STATUS;
         CMD_WRITE_STATUS: op = OP_WRITE_STATUS;
         CMD_SOFT_RESET:   op = OP_SOFT_RESET;
         default:          op = OP_NONE;
      endcase
      return op;
   endfunction

   function automatic logic cmd_is_valid(input logic [CMD_W-1:0] cmd);
      return (cmd >= CMD_TEMPERATURE) && (cmd <= CMD_SOFT_RESET);
   endfunction

endpackage

@@ sv/humidity_sensor_bus_master_core.sv @@
// Tick-driven two-wire temperature and humidity sensor bus master, top level.
// Every request transfer is one bus tick: it may start a command and always carries the
// DATA level sampled in that tick, and it yields exactly one response transfer with the
// SCK level, the DATA release bit, busy, a one-tick done pulse, the acknowledge error
// flag, the 16-bit value read and the raw checksum byte. A command (measure temperature,
// measure humidity, read status, write status, soft reset) is taken only while the
// master is idle; commands during a sequence are ignored. Each tick performs at most
// one pin step, so the caller paces the bus by the rate at which it sends transfers.
// The block takes one transfer per clock cycle: the whole step is computed in one pass
// from the sequencer registers and lands in a response register, and a new request is
// accepted whenever that register is empty or is being emptied in the same cycle, so
// the only thing that slows it down is backpressure on the response side. A measurement
// waits for the sensor to pull DATA low with no timeout; only reset leaves that wait.
// The checksum is passed on unchecked.
`include "assert_macros.svh"

module humidity_sensor_bus_master_core
   import hsbm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Fields from bit 0: command[2:0], write_value[10:3], data_level[11], zero[15:12].
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // Fields from bit 0: sck_level[0], data_release[1], busy_res[2], done_res[3],
   // ack_error[4], read_value[20:5], checksum_byte[28:21], zero[31:29].
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Sequencer phases.
   localparam int PH_W = 5;
   localparam logic [PH_W-1:0] P_IDLE    = 5'd0;
   localparam logic [PH_W-1:0] P_RST_HI  = 5'd1;
   localparam logic [PH_W-1:0] P_RST_LO  = 5'd2;
   localparam logic [PH_W-1:0] P_S1      = 5'd3;
   localparam logic [PH_W-1:0] P_S2      = 5'd4;
   localparam logic [PH_W-1:0] P_S3      = 5'd5;
   localparam logic [PH_W-1:0] P_S4      = 5'd6;
   localparam logic [PH_W-1:0] P_S5      = 5'd7;
   localparam logic [PH_W-1:0] P_S6      = 5'd8;
   localparam logic [PH_W-1:0] P_TX_BIT  = 5'd9;
   localparam logic [PH_W-1:0] P_TX_HI   = 5'd10;
   localparam logic [PH_W-1:0] P_TX_LO   = 5'd11;
   localparam logic [PH_W-1:0] P_ACK_REL = 5'd12;
   localparam logic [PH_W-1:0] P_ACK_HI  = 5'd13;
   localparam logic [PH_W-1:0] P_ACK_LO  = 5'd14;
   localparam logic [PH_W-1:0] P_WAIT    = 5'd15;
   localparam logic [PH_W-1:0] P_RX_HI   = 5'd16;
   localparam logic [PH_W-1:0] P_RX_LO   = 5'd17;
   localparam logic [PH_W-1:0] P_RX_ACKD = 5'd18;
   localparam logic [PH_W-1:0] P_RX_ACKH = 5'd19;
   localparam logic [PH_W-1:0] P_RX_ACKL = 5'd20;
   localparam logic [PH_W-1:0] P_RX_REL  = 5'd21;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;
   localparam logic [3:0] RESET_PULSES  = 4'd9;

   // Request fields.
   logic [CMD_W-1:0]  req_command;
   logic [BYTE_W-1:0] req_write_value;
   logic              req_data_level;

   assign req_command     = req_tdata[2:0];
   assign req_write_value = req_tdata[10:3];
   assign req_data_level  = req_tdata[11];

   // Sequencer state.
   logic [PH_W-1:0]    phase_ff, phase_in;
   logic [3:0]         bit_count_ff, bit_count_in;
   logic [1:0]         byte_count_ff, byte_count_in;
   logic [BYTE_W-1:0]  shift_ff, shift_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [BYTE_W-1:0]  check_ff, check_in;
   logic               error_ff, error_in;
   logic [CMD_W-1:0]   active_op_ff, active_op_in;
   logic [BYTE_W-1:0]  held_value_ff, held_value_in;
   logic [3:0]         pulse_count_ff, pulse_count_in;
   logic               sck_ff, sck_in;
   logic               data_ff, data_in;
   logic               done_in;

   // Response register.
   logic                  rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic req_accept;
   logic finish;
   logic last_byte;

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // The final byte is the checksum: after one data byte for status, two for measurements.
   assign last_byte = (active_op_ff == CMD_READ_STATUS) ? (byte_count_ff >= 2'd1)
                                                        : (byte_count_ff >= 2'd2);

   always_comb begin
      phase_in       = phase_ff;
      bit_count_in   = bit_count_ff;
      byte_count_in  = byte_count_ff;
      shift_in       = shift_ff;
      value_in       = value_ff;
      check_in       = check_ff;
      error_in       = error_ff;
      active_op_in   = active_op_ff;
      held_value_in  = held_value_ff;
      pulse_count_in = pulse_count_ff;
      sck_in         = sck_ff;
      data_in        = data_ff;
      finish         = 1'b0;

      unique case (phase_ff)
         P_IDLE: begin
            sck_in  = 1'b0;
            data_in = 1'b1;
            if (cmd_is_valid(req_command)) begin
               active_op_in   = req_command;
               held_value_in  = req_write_value;
               error_in       = 1'b0;
               value_in       = '0;
               check_in       = '0;
               bit_count_in   = '0;
               byte_count_in  = '0;
               pulse_count_in = '0;
               shift_in       = opcode_of(req_command);
               phase_in       = (req_command == CMD_SOFT_RESET) ? P_RST_HI : P_S1;
            end
         end
         P_RST_HI: begin
            sck_in   = 1'b1;
            phase_in = P_RST_LO;
         end
         P_RST_LO: begin
            // Nine full SCK pulses with DATA released, then the start pattern.
            sck_in         = 1'b0;
            pulse_count_in = pulse_count_ff + 4'd1;
            phase_in       = (pulse_count_in >= RESET_PULSES) ? P_S1 : P_RST_HI;
         end
         P_S1: begin
            sck_in   = 1'b1;
            phase_in = P_S2;
         end
         P_S2: begin
            data_in  = 1'b0;
            phase_in = P_S3;
         end
         P_S3: begin
            sck_in   = 1'b0;
            phase_in = P_S4;
         end
         P_S4: begin
            sck_in   = 1'b1;
            phase_in = P_S5;
         end
         P_S5: begin
            data_in  = 1'b1;
            phase_in = P_S6;
         end
         P_S6: begin
            sck_in       = 1'b0;
            bit_count_in = '0;
            phase_in     = P_TX_BIT;
         end
         P_TX_BIT: begin
            data_in  = shift_ff[BYTE_W-1];
            phase_in = P_TX_HI;
         end
         P_TX_HI: begin
            sck_in   = 1'b1;
            phase_in = P_TX_LO;
         end
         P_TX_LO: begin
            sck_in       = 1'b0;
            shift_in     = {shift_ff[BYTE_W-2:0], 1'b0};
            bit_count_in = bit_count_ff + 4'd1;
            phase_in     = (bit_count_in >= BITS_PER_BYTE) ? P_ACK_REL : P_TX_BIT;
         end
         P_ACK_REL: begin
            data_in  = 1'b1;
            phase_in = P_ACK_HI;
         end
         P_ACK_HI: begin
            sck_in   = 1'b1;
            phase_in = P_ACK_LO;
         end
         P_ACK_LO: begin
            sck_in       = 1'b0;
            bit_count_in = '0;
            if (req_data_level) begin
               error_in = 1'b1;
            end
            priority if (active_op_ff == CMD_WRITE_STATUS) begin
               if (byte_count_ff == 2'd0) begin
                  byte_count_in = 2'd1;
                  shift_in      = held_value_ff;
                  phase_in      = P_TX_BIT;
               end else begin
                  finish = 1'b1;
               end
            end else if (active_op_ff == CMD_READ_STATUS) begin
               byte_count_in = '0;
               phase_in      = P_RX_HI;
            end else if (active_op_ff == CMD_TEMPERATURE ||
                         active_op_ff == CMD_HUMIDITY) begin
               byte_count_in = '0;
               phase_in      = P_WAIT;
            end else begin
               finish = 1'b1;
            end
         end
         P_WAIT: begin
            if (!req_data_level) begin
               phase_in = P_RX_HI;
            end
         end
         P_RX_HI: begin
            sck_in   = 1'b1;
            phase_in = P_RX_LO;
         end
         P_RX_LO: begin
            sck_in       = 1'b0;
            shift_in     = {shift_ff[BYTE_W-2:0], req_data_level};
            bit_count_in = bit_count_ff + 4'd1;
            phase_in     = (bit_count_in >= BITS_PER_BYTE) ? P_RX_ACKD : P_RX_HI;
         end
         P_RX_ACKD: begin
            data_in  = last_byte;
            phase_in = P_RX_ACKH;
         end
         P_RX_ACKH: begin
            sck_in   = 1'b1;
            phase_in = P_RX_ACKL;
         end
         P_RX_ACKL: begin
            sck_in   = 1'b0;
            phase_in = P_RX_REL;
         end
         P_RX_REL: begin
            data_in = 1'b1;
            if (last_byte) begin
               check_in = shift_ff;
               finish   = 1'b1;
            end else begin
               priority if (active_op_ff == CMD_READ_STATUS) begin
                  value_in = {{(VALUE_W-BYTE_W){1'b0}}, shift_ff};
               end else if (byte_count_ff == 2'd0) begin
                  value_in = {shift_ff, value_ff[BYTE_W-1:0]};
               end else begin
                  value_in = {value_ff[VALUE_W-1:BYTE_W], shift_ff};
               end
               byte_count_in = byte_count_ff + 2'd1;
               bit_count_in  = '0;
               phase_in      = P_RX_HI;
            end
         end
         default: begin
            finish = 1'b1;
         end
      endcase

      if (finish) begin
         phase_in = P_IDLE;
         sck_in   = 1'b0;
         data_in  = 1'b1;
      end
      done_in = finish;
   end

   assign rsp_tdata_in = {3'b000, check_in, value_in, error_in, done_in,
                          (phase_in != P_IDLE), data_in, sck_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= P_IDLE;
         bit_count_ff   <= '0;
         byte_count_ff  <= '0;
         shift_ff       <= '0;
         value_ff       <= '0;
         check_ff       <= '0;
         error_ff       <= 1'b0;
         active_op_ff   <= CMD_NONE;
         held_value_ff  <= '0;
         pulse_count_ff <= '0;
         sck_ff         <= 1'b0;
         data_ff        <= 1'b1;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         if (req_accept) begin
            phase_ff       <= phase_in;
            bit_count_ff   <= bit_count_in;
            byte_count_ff  <= byte_count_in;
            shift_ff       <= shift_in;
            value_ff       <= value_in;
            check_ff       <= check_in;
            error_ff       <= error_in;
            active_op_ff   <= active_op_in;
            held_value_ff  <= held_value_in;
            pulse_count_ff <= pulse_count_in;
            sck_ff         <= sck_in;
            data_ff        <= data_in;
            rsp_tvalid_ff  <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   `ASSERT_IMPLY(a_done_not_busy, clock, reset, rsp_tvalid_ff && rsp_tdata_ff[3], !rsp_tdata_ff[2], "done pulse while still busy")
   `ASSERT_IMPLY(a_idle_pins, clock, reset, phase_ff == P_IDLE, !sck_ff && data_ff, "idle bus pins not at rest")
   `ASSERT_NEXT(a_cmd_starts, clock, reset, req_accept && phase_ff == P_IDLE && req_command >= CMD_TEMPERATURE && req_command <= CMD_SOFT_RESET, phase_ff != P_IDLE, "accepted command did not start a sequence")
   `ASSERT_NEXT(a_err_only_on_ack, clock, reset, req_accept && !error_ff && phase_ff != P_ACK_LO, !error_ff, "ack error set outside the acknowledge clock")

endmodule
